// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the mixer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge, off while in reset.
`define ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds at a rising edge, off while in reset.
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(name, prop, msg)
`define ASSERT_NEVER(name, expr, msg)
`endif
`endif

// ----- rtl/pcm_mix_pkg.sv -----
// Package of the PCM sample mixer: sizes, operation codes and the
// request structs passed to the step unit and the shared multiplier.
`default_nettype none
package pcm_mix_pkg;

  // Channel count and sample memory size (memory depth is a power of two)
  localparam int CHANNELS         = 8;
  localparam int SAMPLE_MEM_DEPTH = 65536;
  localparam int MEM_AW           = $clog2(SAMPLE_MEM_DEPTH);
  localparam int CH_W             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_SUM_W       = (MEM_AW > 17) ? MEM_AW : 17;

  // Channel state widths
  localparam int POS_W  = 34;
  localparam int IDX_W  = POS_W - 16;
  localparam int STEP_W = 19;
  localparam int LEN_W  = 16;
  localparam int VOL_W  = 7;
  localparam int MASK_W = 8;

  // Step unit: 16.16 step = rate * 65536 / MIX_RATE_HZ by reciprocal multiply.
  // STEP_RECIP = ceil(2^45 / MIX_RATE_HZ); dropping STEP_SHIFT bits of
  // rate * STEP_RECIP gives the truncated quotient for every 16-bit rate.
  localparam int              MIX_RATE_HZ  = 11025;
  localparam int              RATE_W       = 16;
  localparam int              RECIP_W      = 32;
  localparam logic [RECIP_W-1:0] STEP_RECIP = 32'd3191326267;
  localparam int              STEP_SHIFT   = 29;
  localparam int              RECIP_PROD_W = RATE_W + RECIP_W;

  // Shared multiplier operands and product
  localparam int MUL_W  = 9;
  localparam int PROD_W = 2 * MUL_W;

  // Mix accumulator: one signed 17-bit term per channel
  localparam int SUM_W = 18 + $clog2(CHANNELS);

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_VOLUME = 3'd4
  } op_e;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rate;
  } div_req_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

// ----- rtl/pcm_mix_step_div.sv -----
// Step unit that turns a source rate into the 16.16 channel step with one
// multiply by the scaled reciprocal of the mix rate. Depends on pcm_mix_pkg.
`default_nettype none
module pcm_mix_step_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pcm_mix_pkg::div_req_t         req_i,
  output logic                               done_o,
  output logic [pcm_mix_pkg::STEP_W-1:0]     step_o
);
  import pcm_mix_pkg::*;

  logic                    done_q;
  logic [RECIP_PROD_W-1:0] prod_q;

  // Flag the step in the cycle after the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_i.start;
    end
  end

  // Multiply the rate by the reciprocal and hold the product
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q <= RECIP_PROD_W'(req_i.rate) * RECIP_PROD_W'(STEP_RECIP);
    end
  end

  assign done_o = done_q;
  assign step_o = prod_q[STEP_SHIFT +: STEP_W];

endmodule
`default_nettype wire

// ----- rtl/pcm_mix_mul.sv -----
// Shared signed multiplier with a registered product, used for both the
// interpolation and the volume scaling. Depends on pcm_mix_pkg.
`default_nettype none
module pcm_mix_mul (
  input  wire logic                               clk_i,
  input  wire pcm_mix_pkg::mul_req_t              req_i,
  output logic signed [pcm_mix_pkg::PROD_W-1:0]   prod_o
);
  import pcm_mix_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Multiply and hold the product until the next request
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ----- rtl/pcm_sample_mixer_core.sv -----
// Tick: every channel passes through S_FETCH0; a playing one that has not ended goes on
// through S_FETCH1, S_INTERP, S_SCALE and S_ACCUM on the shared multiplier, then S_DONE.
// Start: S_DIV stores the step, which comes from one reciprocal multiply.
// Write, stop and volume requests stay in S_IDLE. Next request the cycle after.
// Reset (async, active low) stops all channels and clears their state;
// the sample memory is not cleared and reads are defined only once written.
`default_nettype none
`include "assert_macros.svh"
module pcm_sample_mixer_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [2:0]         channel_i,
  input  wire logic [15:0]        address_i,
  input  wire logic [7:0]         sample_byte_i,
  input  wire logic [15:0]        sound_length_i,
  input  wire logic [15:0]        source_rate_i,
  input  wire logic [6:0]         volume_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      mixed_sample_o,
  output logic [7:0]              playing_mask_o
);
  import pcm_mix_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_FETCH0 = 8'b0000_0100,
    S_FETCH1 = 8'b0000_1000,
    S_INTERP = 8'b0001_0000,
    S_SCALE  = 8'b0010_0000,
    S_ACCUM  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  localparam logic signed [SUM_W-1:0] SMP_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SMP_MIN = SUM_W'(-32768);

  state_e state_q, state_d;

  logic            accept;
  logic            ch_ok;
  logic [CH_W-1:0] cmd_ch;
  logic [CH_W-1:0] cmd_ch_q;
  logic [CH_W-1:0] ch_q;
  logic            last_ch;

  // Channel state
  logic [LEN_W-1:0]  start_q [CHANNELS];
  logic [LEN_W-1:0]  len_q   [CHANNELS];
  logic [POS_W-1:0]  pos_q   [CHANNELS];
  logic [STEP_W-1:0] step_q  [CHANNELS];
  logic [VOL_W-1:0]  vol_q   [CHANNELS];
  logic [CHANNELS-1:0] playing_q;

  // Sample memory
  logic [7:0]        mem_q [SAMPLE_MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic [MEM_AW-1:0] mem_raddr;
  logic [MEM_AW-1:0] a0_addr;
  logic [MEM_AW-1:0] addr_q;

  // Per channel datapath
  logic [IDX_W-1:0]         idx;
  logic                     ended;
  logic                     last_smp;
  logic                     last_q;
  logic [7:0]               frac_q;
  logic signed [MUL_W-1:0]  cur_smp;
  logic signed [MUL_W-1:0]  s0_q;
  logic signed [MUL_W-1:0]  s1;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] interp_sum;
  logic signed [PROD_W-1:0] interp_adj;
  logic signed [PROD_W-1:0] prod_abs;
  logic                     neg;
  logic [13:0]              mag;
  logic [21:0]              mag129;
  logic [7:0]               q0;
  logic [14:0]              rem127;
  logic [7:0]               quot;
  logic signed [8:0]        quot_s;
  logic signed [SUM_W-1:0]  contrib;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [15:0]       clamped;

  mul_req_t mul_req;
  div_req_t div_req;
  logic              div_done;
  logic [STEP_W-1:0] div_step;

  // Output register
  logic               out_valid_q;
  logic               out_load;
  logic signed [15:0] mixed_q;
  logic [MASK_W-1:0]  mask_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmd_ch     = CH_W'(channel_i);
  assign ch_ok      = 32'(channel_i) < CHANNELS;
  assign last_ch    = (ch_q == CH_W'(CHANNELS - 1));

  // Decode the current channel's position
  assign idx      = pos_q[ch_q][POS_W-1:16];
  assign ended    = idx >= IDX_W'(len_q[ch_q]);
  assign last_smp = (17'(idx[15:0]) + 17'd1) >= 17'(len_q[ch_q]);
  assign a0_addr  = MEM_AW'(ADDR_SUM_W'(start_q[ch_q]) + ADDR_SUM_W'(idx[15:0]));
  assign mem_raddr = (state_q == S_FETCH0) ? a0_addr : addr_q + MEM_AW'(1);

  // Center the byte just read
  assign cur_smp = $signed({1'b0, rdata_q}) - 9'sd128;
  assign s1      = last_q ? s0_q : cur_smp;

  // Interpolated value, divided by 256 toward zero
  assign interp_sum = (PROD_W'(s0_q) <<< 8) + prod;
  assign interp_adj = interp_sum[PROD_W-1] ? interp_sum + PROD_W'(255) : interp_sum;

  // Volume product divided by 127 toward zero: reciprocal 129/2^14, one fixup
  assign neg      = prod[PROD_W-1];
  assign prod_abs = neg ? -prod : prod;
  assign mag      = prod_abs[13:0];
  assign mag129   = (22'(mag) << 7) + 22'(mag);
  assign q0       = mag129[21:14];
  assign rem127   = {1'b0, mag} - ({q0, 7'b0} - {7'b0, q0});
  assign quot     = q0 + {7'b0, (rem127 >= 15'd127)};
  assign quot_s   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign contrib  = SUM_W'(quot_s) <<< 8;

  // Clamp the mix to 16 bits
  assign clamped = (sum_q > SMP_MAX) ? 16'sh7FFF :
                   (sum_q < SMP_MIN) ? 16'sh8000 : sum_q[15:0];

  // Drive the shared multiplier
  always_comb begin
    mul_req = '0;
    if (state_q == S_INTERP) begin
      mul_req.en = 1'b1;
      mul_req.a  = s1 - s0_q;
      mul_req.b  = $signed({1'b0, frac_q});
    end else if (state_q == S_SCALE) begin
      mul_req.en = 1'b1;
      mul_req.a  = $signed(interp_adj[MUL_W+7:8]);
      mul_req.b  = $signed({2'b0, vol_q[ch_q]});
    end
  end

  assign div_req.start = accept && (operation_i == OP_START) && ch_ok;
  assign div_req.rate  = source_rate_i;

  pcm_mix_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  pcm_mix_step_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .step_o (div_step)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && operation_i == OP_TICK) begin
          state_d = S_FETCH0;
        end else if (div_req.start) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_IDLE;
        end
      end
      S_FETCH0: begin
        if (!playing_q[ch_q] || ended) begin
          state_d = last_ch ? S_DONE : S_FETCH0;
        end else begin
          state_d = S_FETCH1;
        end
      end
      S_FETCH1: state_d = S_INTERP;
      S_INTERP: state_d = S_SCALE;
      S_SCALE:  state_d = S_ACCUM;
      S_ACCUM:  state_d = last_ch ? S_DONE : S_FETCH0;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Control state and channel registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= '0;
      cmd_ch_q  <= '0;
      sum_q     <= '0;
      playing_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        start_q[i] <= '0;
        len_q[i]   <= '0;
        pos_q[i]   <= '0;
        step_q[i]  <= '0;
        vol_q[i]   <= '0;
      end
    end else begin
      state_q <= state_d;
      // Apply channel requests
      if (accept) begin
        cmd_ch_q <= cmd_ch;
        unique case (operation_i)
          OP_TICK: begin
            ch_q  <= '0;
            sum_q <= '0;
          end
          OP_START: begin
            if (ch_ok) begin
              start_q[cmd_ch]   <= address_i;
              len_q[cmd_ch]     <= sound_length_i;
              pos_q[cmd_ch]     <= '0;
              vol_q[cmd_ch]     <= volume_i;
              playing_q[cmd_ch] <= 1'b1;
            end
          end
          OP_STOP: begin
            if (ch_ok) begin
              playing_q[cmd_ch] <= 1'b0;
            end
          end
          OP_VOLUME: begin
            if (ch_ok) begin
              vol_q[cmd_ch] <= volume_i;
            end
          end
          default: ;
        endcase
      end
      // Store the step once the divider finishes
      if (state_q == S_DIV && div_done) begin
        step_q[cmd_ch_q] <= div_step;
      end
      // Stop a channel past its end, or skip an idle one
      if (state_q == S_FETCH0 && (!playing_q[ch_q] || ended)) begin
        playing_q[ch_q] <= 1'b0;
        if (!last_ch) begin
          ch_q <= ch_q + CH_W'(1);
        end
      end
      // Accumulate and advance the position
      if (state_q == S_ACCUM) begin
        sum_q       <= sum_q + contrib;
        pos_q[ch_q] <= pos_q[ch_q] + POS_W'(step_q[ch_q]);
        if (!last_ch) begin
          ch_q <= ch_q + CH_W'(1);
        end
      end
    end
  end

  // Hold fetch results for the interpolation
  always_ff @(posedge clk_i) begin
    if (state_q == S_FETCH0) begin
      addr_q <= a0_addr;
      frac_q <= pos_q[ch_q][15:8];
      last_q <= last_smp;
    end
    if (state_q == S_FETCH1) begin
      s0_q <= cur_smp;
    end
  end

  // Sample memory: write on byte requests, registered read
  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_WRITE) begin
      mem_q[MEM_AW'(address_i)] <= sample_byte_i;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mixed_q <= clamped;
      mask_q  <= MASK_W'(playing_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_q;
  assign playing_mask_o = mask_q;

  `ASSERT_PROP(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without finished tick")
  `ASSERT_PROP(a_div_in_div, div_done |-> (state_q == S_DIV), "divider done outside start")
  `ASSERT_PROP(a_scale_after_interp, (state_q == S_SCALE) |-> $past(state_q == S_INTERP), "scale out of order")
  `ASSERT_PROP(a_tick_clean, (accept && operation_i == OP_TICK) |=> (ch_q == '0 && sum_q == '0), "tick not cleared")
  `ASSERT_NEVER(a_no_load_busy, out_load && out_valid_q && out_stall_i, "result overwritten")

endmodule
`default_nettype wire

// ----- verif/pcm_mix_scoreboard_pkg.sv -----
// Scoreboard for the PCM sample mixer testbench: a per-tick predictor of the mix
// and the queue of expected mixed samples. Depends on pcm_mix_pkg for sizes and codes.
package pcm_mix_scoreboard_pkg;
  import pcm_mix_pkg::*;

  typedef struct {
    logic signed [15:0] sample;
    logic [MASK_W-1:0]  mask;
  } mix_result_t;

  class mixer_scoreboard;
    logic [7:0]        sample_mem [SAMPLE_MEM_DEPTH];
    bit                mem_written [SAMPLE_MEM_DEPTH];
    logic [MEM_AW-1:0] ch_base [CHANNELS];
    logic [LEN_W-1:0]  ch_len [CHANNELS];
    logic [POS_W-1:0]  ch_pos [CHANNELS];
    logic [STEP_W-1:0] ch_step [CHANNELS];
    logic [VOL_W-1:0]  ch_vol [CHANNELS];
    bit                ch_on [CHANNELS];
    mix_result_t       expected_mix [$];
    int unsigned       mismatches;
    int unsigned       mixes_checked;
    int unsigned       starts_seen;
    int unsigned       clamp_hits;

    function new();
      foreach (ch_on[c]) begin
        ch_base[c] = '0;
        ch_len[c]  = '0;
        ch_pos[c]  = '0;
        ch_step[c] = '0;
        ch_vol[c]  = '0;
        ch_on[c]   = 1'b0;
      end
      foreach (sample_mem[a]) sample_mem[a] = '0;
      mismatches    = 0;
      mixes_checked = 0;
      starts_seen   = 0;
      clamp_hits    = 0;
    endfunction

    // Memory address of sample idx of a channel's sound, wrapped to the memory size
    function int unsigned sound_addr(int c, int unsigned idx);
      return (int'(ch_base[c]) + idx) % SAMPLE_MEM_DEPTH;
    endfunction

    // Advance every playing channel by one tick and build the expected mix
    function mix_result_t mix_tick();
      mix_result_t r;
      int          sum;
      int unsigned idx;
      int unsigned a0;
      int          frac;
      int          s0;
      int          s1;
      int          v;
      sum    = 0;
      r.mask = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_on[c]) begin
          idx = int'(ch_pos[c] >> 16);
          if (idx >= ch_len[c]) begin
            ch_on[c] = 1'b0;
          end else begin
            a0   = sound_addr(c, idx);
            frac = int'(ch_pos[c][15:8]);
            s0   = int'(sample_mem[a0]) - 128;
            s1   = (idx + 1 < ch_len[c]) ? int'(sample_mem[sound_addr(c, idx + 1)]) - 128 : s0;
            v    = (s0 * (256 - frac) + s1 * frac) / 256;
            v    = v * int'(ch_vol[c]) / 127;
            sum += v * 256;
            ch_pos[c] = ch_pos[c] + POS_W'(ch_step[c]);
          end
        end
        if (ch_on[c] && c < MASK_W) r.mask[c] = 1'b1;
      end
      if (sum > 32767 || sum < -32768) clamp_hits++;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      r.sample = 16'(sum);
      return r;
    endfunction

    // Apply one accepted request; a tick queues its expected mix
    function void note_request(logic [2:0] op, logic [2:0] ch, logic [15:0] addr,
                               logic [7:0] sample_val, logic [15:0] len,
                               logic [15:0] rate, logic [6:0] vol);
      longint unsigned scaled;
      bit              ch_ok;
      ch_ok = (int'(ch) < CHANNELS);
      if (op == OP_TICK) begin
        expected_mix.push_back(mix_tick());
      end else if (op == OP_WRITE) begin
        sample_mem[int'(addr) % SAMPLE_MEM_DEPTH]  = sample_val;
        mem_written[int'(addr) % SAMPLE_MEM_DEPTH] = 1'b1;
      end else if (op == OP_START && ch_ok) begin
        scaled      = longint'(rate) << 16;
        ch_base[ch] = MEM_AW'(addr);
        ch_len[ch]  = len;
        ch_pos[ch]  = '0;
        ch_step[ch] = STEP_W'(scaled / MIX_RATE_HZ);
        ch_vol[ch]  = vol;
        ch_on[ch]   = 1'b1;
        starts_seen++;
      end else if (op == OP_STOP && ch_ok) begin
        ch_on[ch] = 1'b0;
      end else if (op == OP_VOLUME && ch_ok) begin
        ch_vol[ch] = vol;
      end
    endfunction

    // Find a byte that the next tick would read before it was ever written
    function bit find_unwritten(output logic [15:0] addr);
      int unsigned idx;
      int unsigned a;
      addr = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (ch_on[c]) begin
          idx = int'(ch_pos[c] >> 16);
          if (idx < ch_len[c]) begin
            a = sound_addr(c, idx);
            if (!mem_written[a]) begin
              addr = 16'(a);
              return 1'b1;
            end
            if (idx + 1 < ch_len[c]) begin
              a = sound_addr(c, idx + 1);
              if (!mem_written[a]) begin
                addr = 16'(a);
                return 1'b1;
              end
            end
          end
        end
      end
      return 1'b0;
    endfunction

    // Compare one accepted result against the oldest expected mix
    function void check_mix(logic signed [15:0] sample, logic [MASK_W-1:0] mask);
      mix_result_t want;
      if (expected_mix.size() == 0) begin
        $error("mixed_sample %0d arrived with no tick pending", sample);
        mismatches++;
        return;
      end
      want = expected_mix.pop_front();
      mixes_checked++;
      if (sample !== want.sample) begin
        $error("mixed_sample: expected %0d, actual %0d", want.sample, sample);
        mismatches++;
      end
      if (mask !== want.mask) begin
        $error("playing_mask: expected %02h, actual %02h", want.mask, mask);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ----- verif/pcm_sample_mixer_core_test.sv -----
// Top of the PCM sample mixer testbench: clock, reset, request and result drivers.
// Depends on pcm_mix_pkg and pcm_mix_scoreboard_pkg; instantiates pcm_sample_mixer_core.
module pcm_sample_mixer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcm_mix_pkg::*;
  import pcm_mix_scoreboard_pkg::*;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_CODE    = 3'd7;
  localparam int         REQUEST_TARGET  = 1250;
  localparam int         QUIET_FROM      = 1100;
  localparam int         DRAIN_CYCLES    = 64;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         operation_i;
  logic [2:0]         channel_i;
  logic [15:0]        address_i;
  logic [7:0]         sample_byte_i;
  logic [15:0]        sound_length_i;
  logic [15:0]        source_rate_i;
  logic [6:0]         volume_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] mixed_sample_o;
  logic [7:0]         playing_mask_o;

  mixer_scoreboard sb = new();
  int unsigned     requests_sent = 0;
  bit              calm = 1'b0;

  pcm_sample_mixer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .channel_i      (channel_i),
    .address_i      (address_i),
    .sample_byte_i  (sample_byte_i),
    .sound_length_i (sound_length_i),
    .source_rate_i  (source_rate_i),
    .volume_i       (volume_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mixed_sample_o (mixed_sample_o),
    .playing_mask_o (playing_mask_o)
  );

  always #1ns clk_i = ~clk_i;

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_mix(mixed_sample_o, playing_mask_o);
    end
  end

  // Stall the result side in short random bursts, none in the quiet tail
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && rst_ni && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Present one request at a falling edge, hold it until accepted, then maybe idle
  task automatic send_request(input logic [2:0] op, input logic [2:0] ch,
                              input logic [15:0] addr, input logic [7:0] sample_val,
                              input logic [15:0] len, input logic [15:0] rate,
                              input logic [6:0] vol);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    channel_i      <= ch;
    address_i      <= addr;
    sample_byte_i  <= sample_val;
    sound_length_i <= len;
    source_rate_i  <= rate;
    volume_i       <= vol;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_request(op, ch, addr, sample_val, len, rate, vol);
    requests_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic write_byte(input logic [15:0] addr, input logic [7:0] sample_val);
    send_request(OP_WRITE, 3'($urandom()), addr, sample_val, 16'($urandom()),
                 16'($urandom()), 7'($urandom()));
  endtask

  task automatic start_channel(input logic [2:0] ch, input logic [15:0] addr,
                               input logic [15:0] len, input logic [15:0] rate,
                               input logic [6:0] vol);
    send_request(OP_START, ch, addr, 8'($urandom()), len, rate, vol);
  endtask

  task automatic stop_channel(input logic [2:0] ch);
    send_request(OP_STOP, ch, 16'($urandom()), 8'($urandom()), 16'($urandom()),
                 16'($urandom()), 7'($urandom()));
  endtask

  task automatic set_volume(input logic [2:0] ch, input logic [6:0] vol);
    send_request(OP_VOLUME, ch, 16'($urandom()), 8'($urandom()), 16'($urandom()),
                 16'($urandom()), vol);
  endtask

  task automatic send_unused_op();
    send_request(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE)), 3'($urandom()),
                 16'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()),
                 7'($urandom()));
  endtask

  // Fill any byte the coming tick would read unwritten, then tick
  task automatic tick();
    logic [15:0] gap_addr;
    while (sb.find_unwritten(gap_addr)) write_byte(gap_addr, 8'($urandom()));
    send_request(OP_TICK, 3'($urandom()), 16'($urandom()), 8'($urandom()),
                 16'($urandom()), 16'($urandom()), 7'($urandom()));
  endtask

  function automatic logic [6:0] pick_volume();
    return ($urandom_range(0, 2) == 0) ? 7'd127 : 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [15:0] pick_rate();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom()) : 16'($urandom_range(1000, 22050));
  endfunction

  // Load a short sound at a random base, then start it
  task automatic load_and_start(input logic [2:0] ch);
    logic [15:0] base;
    logic [15:0] len;
    logic [7:0]  sample_val;
    base = 16'($urandom());
    len  = 16'($urandom_range(1, 16));
    for (int i = 0; i < int'(len); i++) begin
      sample_val = 8'($urandom());
      if ($urandom_range(0, 3) == 0) sample_val = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      write_byte(base + 16'(i), sample_val);
    end
    start_channel(ch, base, len, pick_rate(), pick_volume());
  endtask

  // Start a sound of any length; its bytes get written on demand
  task automatic start_any(input logic [2:0] ch);
    logic [15:0] len;
    case ($urandom_range(0, 3))
      0: len = '0;
      1: len = 16'($urandom_range(1, 16));
      2: len = 16'($urandom());
      default: len = 16'($urandom_range(17, 300));
    endcase
    start_channel(ch, 16'($urandom()), len, pick_rate(), pick_volume());
  endtask

  initial begin
    #2ms;
    $error("run did not complete in time");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_TICK;
    channel_i      = '0;
    address_i      = '0;
    sample_byte_i  = '0;
    sound_length_i = '0;
    source_rate_i  = '0;
    volume_i       = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: wrap at the top of memory, extreme bytes, both clamps
    write_byte(16'hFFFF, 8'hFF);
    write_byte(16'h0000, 8'h00);
    write_byte(16'h0001, 8'hFF);
    start_channel(3'd0, 16'hFFFF, 16'd2, 16'hFFFF, 7'd127);
    start_channel(3'd7, 16'hFFFF, 16'd2, 16'd0, 7'd127);
    tick();
    tick();
    set_volume(3'd7, 7'd0);
    tick();
    start_channel(3'd1, 16'h0000, 16'd1, 16'd11025, 7'd127);
    start_channel(3'd2, 16'h0000, 16'd2, 16'd5512, 7'd100);
    // zero length plays for no ticks
    start_channel(3'd3, 16'h1234, 16'd0, 16'd22050, 7'd127);
    tick();
    send_request(OP_FIRST_UNUSED, 3'd1, '1, '1, '1, '1, '1);
    send_request(OP_LAST_CODE, 3'd2, '0, '0, '0, '0, '0);
    stop_channel(3'd7);
    // restart a playing channel with the longest sound
    start_channel(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
    tick();
    tick();
    stop_channel(3'd1);
    tick();

    // Random: mostly well-formed sound loads and ticks, some noise
    while (requests_sent < REQUEST_TARGET) begin
      calm = (requests_sent > QUIET_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 40) tick();
      else if (pick < 55) load_and_start(3'($urandom()));
      else if (pick < 63) start_any(3'($urandom()));
      else if (pick < 70) stop_channel(3'($urandom()));
      else if (pick < 77) set_volume(3'($urandom()), pick_volume());
      else if (pick < 90) write_byte(16'($urandom()), 8'($urandom()));
      else if (pick < 93) send_unused_op();
      else repeat ($urandom_range(2, 8)) tick();
    end
    in_valid_i <= 1'b0;

    // Drain outstanding mixes, then watch for strays
    while (sb.expected_mix.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests with %0d channel starts; checked %0d mixed samples.",
             requests_sent, sb.starts_seen, sb.mixes_checked);
    $display("Saw %0d clamped mixes; %0d field mismatches.", sb.clamp_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
